### rtl/imcs_pkg.sv
`default_nettype none

package imcs_pkg;

	// Intake modes as carried on the mode field
	typedef enum logic [2:0] {
		MODE_OFF = 3'd0,
		MODE_FWD = 3'd1,
		MODE_REV = 3'd2,
		MODE_LOW = 3'd3,
		MODE_MID = 3'd4,
		MODE_TOP = 3'd5
	} mode_t;

	// Register indexes, byte address = 4 * index
	typedef enum logic [2:0] {
		REG_ALLIANCE_BLUE  = 3'd0,
		REG_SORT_ENABLE    = 3'd1,
		REG_PROX_THRESHOLD = 3'd2,
		REG_SAMPLE_PERIOD  = 3'd3,
		REG_SCORE_LIMIT    = 3'd4,
		REG_SCORE_RISE     = 3'd5,
		REG_SCORE_FALL     = 3'd6,
		REG_REJECT_LEVEL   = 3'd7
	} reg_idx_t;

	// Field widths
	localparam int BTN_W   = 6;
	localparam int PROX_W  = 8;
	localparam int HUE_W   = 9;
	localparam int VEL_W   = 9;
	localparam int SCORE_W = 4;
	localparam int PHASE_W = 4;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 48;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	// Button bit positions inside the button group
	localparam int BTN_FWD  = 0;
	localparam int BTN_REV  = 1;
	localparam int BTN_MID  = 2;
	localparam int BTN_LOW  = 3;
	localparam int BTN_TOP  = 4;
	localparam int BTN_TUBE = 5;

	// Roller commands in rpm
	localparam logic signed [VEL_W-1:0] VEL_POS  = 9'sd200;
	localparam logic signed [VEL_W-1:0] VEL_NEG  = -9'sd200;
	localparam logic signed [VEL_W-1:0] VEL_STOP = 9'sd0;

	// Hue windows in degrees
	localparam logic [HUE_W-1:0] RED_LO  = 9'd300;
	localparam logic [HUE_W-1:0] RED_HI  = 9'd360;
	localparam logic [HUE_W-1:0] BLUE_LO = 9'd215;
	localparam logic [HUE_W-1:0] BLUE_HI = 9'd250;

	// Register reset values
	localparam logic               RST_ALLIANCE_BLUE = 1'b0;
	localparam logic               RST_SORT_ENABLE   = 1'b1;
	localparam logic [PROX_W-1:0]  RST_PROX_THR      = 8'd40;
	localparam logic [PHASE_W-1:0] RST_SAMPLE_PERIOD = 4'd3;
	localparam logic [SCORE_W-1:0] RST_SCORE_LIMIT   = 4'd10;
	localparam logic [SCORE_W-1:0] RST_SCORE_RISE    = 4'd5;
	localparam logic [SCORE_W-1:0] RST_SCORE_FALL    = 4'd3;
	localparam logic [SCORE_W-1:0] RST_REJECT_LEVEL  = 4'd3;

endpackage

`default_nettype wire

### rtl/intake_mode_color_sorter_core.sv
`default_nettype none

// Channel  | Direction | Handshake              | Payload
// s_axis   | in        | s_axis_tvalid/tready   | buttons, proximity, hue (24 bits)
// m_axis   | out       | m_axis_tvalid/tready   | mode, solenoids, 4 rollers, score (48 bits)
// apb      | in        | psel/penable, pready=1 | 8 registers at 4*index
//
// One item per cycle sustained while the output is not stalled; a taken item passes
// through the input register and is then held in the result register.
// All mode, score and phase state is updated in the single cycle an item
// moves from the input register to the result register.
// Reset clears all block state and valid flags and sets the registers to their defaults.
// While the result register is stalled the input register still takes one item.

module intake_mode_color_sorter_core (
	input  wire                              clk,
	input  wire                              arst_n,
	// stream in
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// [0] btn_forward [1] btn_reverse [2] btn_middle [3] btn_low [4] btn_top
	// [5] btn_tube [13:6] proximity [22:14] hue_deg [23] zero
	input  wire  [imcs_pkg::IN_W-1:0]        s_axis_tdata,
	// stream out
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// [2:0] mode [3] hood_out [4] tube_out [13:5] front_velocity
	// [22:14] back_velocity [31:23] top_velocity [40:32] index_velocity
	// [44:41] reject_score [47:45] zero
	output logic [imcs_pkg::OUT_W-1:0]       m_axis_tdata,
	// configuration
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [imcs_pkg::APB_AW-1:0]      paddr,
	input  wire  [imcs_pkg::APB_DW-1:0]      pwdata,
	output logic [imcs_pkg::APB_DW-1:0]      prdata,
	output logic                             pready
);

	// configuration registers
	logic                               alliance_blue_q;
	logic                               sort_enable_q;
	logic [imcs_pkg::PROX_W-1:0]        prox_thr_q;
	logic [imcs_pkg::PHASE_W-1:0]       sample_period_q;
	logic [imcs_pkg::SCORE_W-1:0]       score_limit_q;
	logic [imcs_pkg::SCORE_W-1:0]       score_rise_q;
	logic [imcs_pkg::SCORE_W-1:0]       score_fall_q;
	logic [imcs_pkg::SCORE_W-1:0]       reject_level_q;
	imcs_pkg::reg_idx_t                 reg_idx;
	logic                               cfg_wr;

	// block state
	logic [imcs_pkg::BTN_W-1:0]         prev_btn_q;
	imcs_pkg::mode_t                    mode_q;
	logic                               hood_q;
	logic                               tube_q;
	logic [imcs_pkg::SCORE_W-1:0]       score_q;
	logic [imcs_pkg::PHASE_W-1:0]       phase_q;
	logic signed [imcs_pkg::VEL_W-1:0]  last_top_q;

	// input register
	logic                               vld_s1;
	logic [imcs_pkg::BTN_W-1:0]         btn_s1;
	logic [imcs_pkg::PROX_W-1:0]        prox_s1;
	logic [imcs_pkg::HUE_W-1:0]         hue_s1;

	// result register
	logic                               vld_s2;
	imcs_pkg::mode_t                    mode_s2;
	logic                               hood_s2;
	logic                               tube_s2;
	logic signed [imcs_pkg::VEL_W-1:0]  front_s2;
	logic signed [imcs_pkg::VEL_W-1:0]  back_s2;
	logic signed [imcs_pkg::VEL_W-1:0]  top_s2;
	logic signed [imcs_pkg::VEL_W-1:0]  idx_s2;
	logic [imcs_pkg::SCORE_W-1:0]       score_s2;

	// next-state values
	logic                               in_acc;
	logic                               fire;
	logic [imcs_pkg::BTN_W-1:0]         rise;
	imcs_pkg::mode_t                    mode_n;
	logic                               hood_n;
	logic                               tube_n;
	logic                               opposing;
	logic                               is_red;
	logic                               is_blue;
	logic [imcs_pkg::SCORE_W:0]         score_sum;
	logic [imcs_pkg::SCORE_W-1:0]       score_n;
	logic [imcs_pkg::PHASE_W-1:0]       period;
	logic [imcs_pkg::PHASE_W:0]         phase_inc;
	logic [imcs_pkg::PHASE_W-1:0]       phase_n;
	logic signed [imcs_pkg::VEL_W-1:0]  front_n;
	logic signed [imcs_pkg::VEL_W-1:0]  back_n;
	logic signed [imcs_pkg::VEL_W-1:0]  top_n;
	logic signed [imcs_pkg::VEL_W-1:0]  idx_n;

	// APB register file
	assign pready  = 1'b1;
	assign reg_idx = imcs_pkg::reg_idx_t'(paddr[imcs_pkg::APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alliance_blue_q <= imcs_pkg::RST_ALLIANCE_BLUE;
			sort_enable_q   <= imcs_pkg::RST_SORT_ENABLE;
			prox_thr_q      <= imcs_pkg::RST_PROX_THR;
			sample_period_q <= imcs_pkg::RST_SAMPLE_PERIOD;
			score_limit_q   <= imcs_pkg::RST_SCORE_LIMIT;
			score_rise_q    <= imcs_pkg::RST_SCORE_RISE;
			score_fall_q    <= imcs_pkg::RST_SCORE_FALL;
			reject_level_q  <= imcs_pkg::RST_REJECT_LEVEL;
		end else if (cfg_wr) begin
			case (reg_idx)
				imcs_pkg::REG_ALLIANCE_BLUE:  alliance_blue_q <= pwdata[0];
				imcs_pkg::REG_SORT_ENABLE:    sort_enable_q   <= pwdata[0];
				imcs_pkg::REG_PROX_THRESHOLD: prox_thr_q      <= pwdata[imcs_pkg::PROX_W-1:0];
				imcs_pkg::REG_SAMPLE_PERIOD:  sample_period_q <= pwdata[imcs_pkg::PHASE_W-1:0];
				imcs_pkg::REG_SCORE_LIMIT:    score_limit_q   <= pwdata[imcs_pkg::SCORE_W-1:0];
				imcs_pkg::REG_SCORE_RISE:     score_rise_q    <= pwdata[imcs_pkg::SCORE_W-1:0];
				imcs_pkg::REG_SCORE_FALL:     score_fall_q    <= pwdata[imcs_pkg::SCORE_W-1:0];
				imcs_pkg::REG_REJECT_LEVEL:   reject_level_q  <= pwdata[imcs_pkg::SCORE_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		case (reg_idx)
			imcs_pkg::REG_ALLIANCE_BLUE:  prdata[0] = alliance_blue_q;
			imcs_pkg::REG_SORT_ENABLE:    prdata[0] = sort_enable_q;
			imcs_pkg::REG_PROX_THRESHOLD: prdata[imcs_pkg::PROX_W-1:0] = prox_thr_q;
			imcs_pkg::REG_SAMPLE_PERIOD:  prdata[imcs_pkg::PHASE_W-1:0] = sample_period_q;
			imcs_pkg::REG_SCORE_LIMIT:    prdata[imcs_pkg::SCORE_W-1:0] = score_limit_q;
			imcs_pkg::REG_SCORE_RISE:     prdata[imcs_pkg::SCORE_W-1:0] = score_rise_q;
			imcs_pkg::REG_SCORE_FALL:     prdata[imcs_pkg::SCORE_W-1:0] = score_fall_q;
			imcs_pkg::REG_REJECT_LEVEL:   prdata[imcs_pkg::SCORE_W-1:0] = reject_level_q;
			default: prdata = '0;
		endcase
	end

	// handshake: s1 advances whenever the result register is free or drains
	assign fire          = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || fire;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			btn_s1  <= s_axis_tdata[imcs_pkg::BTN_W-1:0];
			prox_s1 <= s_axis_tdata[13:6];
			hue_s1  <= s_axis_tdata[22:14];
		end
	end

	// button edges and mode toggles, applied in order fwd, rev, mid, low, top; a later toggle overrides
	always_comb begin
		rise   = btn_s1 & ~prev_btn_q;
		mode_n = mode_q;
		hood_n = hood_q;
		tube_n = tube_q;
		if (rise[imcs_pkg::BTN_FWD]) begin
			mode_n = (mode_n == imcs_pkg::MODE_FWD) ? imcs_pkg::MODE_OFF : imcs_pkg::MODE_FWD;
			if (mode_n == imcs_pkg::MODE_FWD) begin
				hood_n = 1'b0;
			end
		end
		if (rise[imcs_pkg::BTN_REV]) begin
			mode_n = (mode_n == imcs_pkg::MODE_REV) ? imcs_pkg::MODE_OFF : imcs_pkg::MODE_REV;
		end
		if (rise[imcs_pkg::BTN_MID]) begin
			mode_n = (mode_n == imcs_pkg::MODE_MID) ? imcs_pkg::MODE_OFF : imcs_pkg::MODE_MID;
		end
		if (rise[imcs_pkg::BTN_LOW]) begin
			mode_n = (mode_n == imcs_pkg::MODE_LOW) ? imcs_pkg::MODE_OFF : imcs_pkg::MODE_LOW;
		end
		if (rise[imcs_pkg::BTN_TOP]) begin
			mode_n = (mode_n == imcs_pkg::MODE_TOP) ? imcs_pkg::MODE_OFF : imcs_pkg::MODE_TOP;
			if (mode_n == imcs_pkg::MODE_TOP) begin
				hood_n = 1'b1;
				tube_n = 1'b0;
			end
		end
		// tube button is handled after the mode buttons
		if (rise[imcs_pkg::BTN_TUBE]) begin
			tube_n = ~tube_n;
		end
	end

	// opposing color detection
	always_comb begin
		is_red   = (hue_s1 >= imcs_pkg::RED_LO) && (hue_s1 <= imcs_pkg::RED_HI);
		is_blue  = (hue_s1 >= imcs_pkg::BLUE_LO) && (hue_s1 <= imcs_pkg::BLUE_HI);
		opposing = 1'b0;
		if (sort_enable_q && (prox_s1 > prox_thr_q)) begin
			if (is_red) begin
				opposing = alliance_blue_q;
			end else if (is_blue) begin
				opposing = !alliance_blue_q;
			end
		end
	end

	// saturating score, updated on phase zero in forward mode and cleared in any other mode
	always_comb begin
		score_sum = {1'b0, score_q} + {1'b0, score_rise_q};
		score_n   = score_q;
		if (mode_n != imcs_pkg::MODE_FWD) begin
			score_n = '0;
		end else if (phase_q == '0) begin
			if (opposing) begin
				score_n = (score_sum > {1'b0, score_limit_q}) ? score_limit_q
					: score_sum[imcs_pkg::SCORE_W-1:0];
			end else begin
				score_n = (score_q > score_fall_q) ? (score_q - score_fall_q) : '0;
			end
		end
	end

	// sample phase, a zero period counts as one
	always_comb begin
		period    = (sample_period_q == '0) ? imcs_pkg::PHASE_W'(1) : sample_period_q;
		phase_inc = {1'b0, phase_q} + (imcs_pkg::PHASE_W+1)'(1);
		phase_n   = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[imcs_pkg::PHASE_W-1:0];
	end

	// roller commands per mode
	always_comb begin
		front_n = imcs_pkg::VEL_STOP;
		back_n  = imcs_pkg::VEL_STOP;
		top_n   = imcs_pkg::VEL_STOP;
		idx_n   = imcs_pkg::VEL_STOP;
		case (mode_n)
			imcs_pkg::MODE_FWD: begin
				front_n = imcs_pkg::VEL_POS;
				back_n  = imcs_pkg::VEL_POS;
				top_n   = (score_n >= reject_level_q) ? imcs_pkg::VEL_NEG : imcs_pkg::VEL_POS;
			end
			imcs_pkg::MODE_REV: begin
				front_n = imcs_pkg::VEL_NEG;
				back_n  = imcs_pkg::VEL_NEG;
				top_n   = imcs_pkg::VEL_NEG;
			end
			imcs_pkg::MODE_MID: begin
				front_n = imcs_pkg::VEL_POS;
				back_n  = imcs_pkg::VEL_POS;
				top_n   = imcs_pkg::VEL_NEG;
				idx_n   = imcs_pkg::VEL_POS;
			end
			imcs_pkg::MODE_LOW: begin
				front_n = imcs_pkg::VEL_NEG;
				back_n  = imcs_pkg::VEL_POS;
				top_n   = last_top_q;
				idx_n   = imcs_pkg::VEL_POS;
			end
			imcs_pkg::MODE_TOP: begin
				front_n = imcs_pkg::VEL_POS;
				back_n  = imcs_pkg::VEL_POS;
				top_n   = imcs_pkg::VEL_POS;
				idx_n   = imcs_pkg::VEL_POS;
			end
			default: ;
		endcase
	end

	// state update, one item per fire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_btn_q <= '0;
			mode_q     <= imcs_pkg::MODE_OFF;
			hood_q     <= 1'b0;
			tube_q     <= 1'b0;
			score_q    <= '0;
			phase_q    <= '0;
			last_top_q <= imcs_pkg::VEL_STOP;
		end else if (fire) begin
			prev_btn_q <= btn_s1;
			mode_q     <= mode_n;
			hood_q     <= hood_n;
			tube_q     <= tube_n;
			score_q    <= score_n;
			phase_q    <= phase_n;
			last_top_q <= top_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (fire) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mode_s2  <= mode_n;
			hood_s2  <= hood_n;
			tube_s2  <= tube_n;
			front_s2 <= front_n;
			back_s2  <= back_n;
			top_s2   <= top_n;
			idx_s2   <= idx_n;
			score_s2 <= score_n;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {3'b000, score_s2, idx_s2, top_s2, back_s2, front_s2,
		tube_s2, hood_s2, mode_s2};

endmodule

`default_nettype wire

### rtl/imcs_checker.sv
`default_nettype none

module imcs_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        m_axis_tvalid,
	input wire                        m_axis_tready,
	input wire [imcs_pkg::OUT_W-1:0]  m_axis_tdata
);

	logic [2:0] mode_f;
	logic [3:0] score_f;

	assign mode_f  = m_axis_tdata[2:0];
	assign score_f = m_axis_tdata[44:41];

	// stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// score is cleared outside forward mode
	a_score_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (score_f != 4'd0) |-> mode_f == imcs_pkg::MODE_FWD)
		else $error("nonzero score outside forward mode");

	// forward mode drives front and back rollers inward
	a_fwd_rollers: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (mode_f == imcs_pkg::MODE_FWD) |->
		(m_axis_tdata[13:5] == imcs_pkg::VEL_POS) && (m_axis_tdata[22:14] == imcs_pkg::VEL_POS))
		else $error("forward mode roller mismatch");

	// hood is raised whenever top-goal mode is active
	a_top_hood: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (mode_f == imcs_pkg::MODE_TOP) |-> m_axis_tdata[3])
		else $error("hood down in top-goal mode");

endmodule

bind intake_mode_color_sorter_core imcs_checker u_imcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
